// ===== hw/rtl/frer_vr_pkg.sv =====
`default_nettype none

package frer_vr_pkg;

  localparam int unsigned SeqW   = 16;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned TmoW   = 32;
  localparam int unsigned CauseW = 3;

  typedef enum logic [CauseW-1:0] {
    CauseRestart = 3'd0,
    CauseAdvance = 3'd1,
    CauseGap     = 3'd2,
    CauseDup     = 3'd3,
    CauseOutside = 3'd4
  } cause_e;

  typedef struct packed {
    logic   accept;
    cause_e cause;
  } verdict_t;

endpackage

`default_nettype wire

// ===== hw/rtl/frer_vector_recovery.sv =====
// Duplicate elimination for one redundant stream.
// Input channel (in_valid_i/in_ready_o): one beat per frame, carrying the
// 16-bit sequence number and the 64-bit arrival time in ns.
// Output channel (out_valid_o/out_ready_i): exactly one beat per input
// beat, in order: accept_o forwards or drops the frame, cause_o tells why
// (restart, advanced window, filled gap, duplicate, outside window).
// Configuration channel (cfg_valid_i/cfg_ready_o): writes the 32-bit
// recovery timeout; always ready; write it only while no frame is in flight.
// A beat is held in the input register while it is decided, and its result
// then sits in the result register until the receiver takes it.
// Throughput: one frame per cycle while the receiver takes results; the
// window update for a frame is made between the input register and the
// result register and registered with its result; the next frame sees it.
// When the receiver stalls, the result register holds its beat, the input
// register takes one more beat, and in_ready_o then drops.
// Reset clears the window (not valid), the timeout, the last seen time and
// both pipeline valids; the first frame after reset restarts the window.
`default_nettype none

module frer_vector_recovery #(
  parameter int unsigned WINDOW = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [frer_vr_pkg::SeqW-1:0]         sequence_req_i,
  input  wire logic [frer_vr_pkg::TimeW-1:0]        now_time_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      accept_o,
  output logic      [frer_vr_pkg::CauseW-1:0]       cause_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [frer_vr_pkg::TmoW-1:0]         recovery_timeout_i
);

  logic                           s1_valid_q;
  logic [frer_vr_pkg::SeqW-1:0]   s1_seq_q;
  logic [frer_vr_pkg::TimeW-1:0]  s1_now_q;
  logic                           s1_fire;

  logic                           out_valid_q;
  frer_vr_pkg::verdict_t          verdict_q;
  frer_vr_pkg::verdict_t          verdict_d;

  logic [frer_vr_pkg::TmoW-1:0]   timeout_q;
  logic                           win_valid_q;
  logic [frer_vr_pkg::SeqW-1:0]   base_q;
  logic [frer_vr_pkg::SeqW-1:0]   base_d;
  logic [WINDOW-1:0]              seen_q;
  logic [WINDOW-1:0]              seen_d;
  logic [frer_vr_pkg::TimeW-1:0]  last_q;

  // advance the decision stage when the result register is free or drains
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign accept_o    = verdict_q.accept;
  assign cause_o     = verdict_q.cause;

  frer_vr_decide #(
    .WINDOW (WINDOW)
  ) u_decide (
    .valid_i   (win_valid_q),
    .base_i    (base_q),
    .seen_i    (seen_q),
    .last_i    (last_q),
    .timeout_i (timeout_q),
    .seq_i     (s1_seq_q),
    .now_i     (s1_now_q),
    .verdict_o (verdict_d),
    .base_d_o  (base_d),
    .seen_d_o  (seen_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= '0;
      win_valid_q <= 1'b0;
      base_q      <= '0;
      seen_q      <= '0;
      last_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (cfg_valid_i) begin
        timeout_q <= recovery_timeout_i;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        win_valid_q <= 1'b1;
        base_q      <= base_d;
        seen_q      <= seen_d;
        last_q      <= s1_now_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_seq_q <= sequence_req_i;
      s1_now_q <= now_time_i;
    end
    if (s1_fire) begin
      verdict_q <= verdict_d;
    end
  end

  a_accept_matches_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accept_o == ((verdict_q.cause == frer_vr_pkg::CauseRestart) ||
                                  (verdict_q.cause == frer_vr_pkg::CauseAdvance) ||
                                  (verdict_q.cause == frer_vr_pkg::CauseGap))))
    else $error("accept disagrees with cause");

  a_base_seen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid_q |-> seen_q[0])
    else $error("base sequence not marked seen");

  a_window_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (win_valid_q && out_valid_o))
    else $error("decision did not update window and result");

  a_stall_holds_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |=> (s1_valid_q && $stable(s1_seq_q)))
    else $error("decision stage lost a beat under stall");

endmodule

`default_nettype wire

// ===== hw/rtl/frer_vr_decide.sv =====
`default_nettype none

module frer_vr_decide #(
  parameter int unsigned WINDOW = 64
) (
  input  wire logic                                valid_i,
  input  wire logic [frer_vr_pkg::SeqW-1:0]        base_i,
  input  wire logic [WINDOW-1:0]                   seen_i,
  input  wire logic [frer_vr_pkg::TimeW-1:0]       last_i,
  input  wire logic [frer_vr_pkg::TmoW-1:0]        timeout_i,
  input  wire logic [frer_vr_pkg::SeqW-1:0]        seq_i,
  input  wire logic [frer_vr_pkg::TimeW-1:0]       now_i,
  output frer_vr_pkg::verdict_t                    verdict_o,
  output logic      [frer_vr_pkg::SeqW-1:0]        base_d_o,
  output logic      [WINDOW-1:0]                   seen_d_o
);

  localparam logic [frer_vr_pkg::SeqW-1:0] WinW = frer_vr_pkg::SeqW'(WINDOW);

  logic [frer_vr_pkg::TimeW-1:0] idle;
  logic                          timed_out;
  logic                          restart;
  logic [frer_vr_pkg::SeqW-1:0]  ahead;
  logic [frer_vr_pkg::SeqW-1:0]  offset;
  logic                          newer;
  logic [WINDOW-1:0]             bit_m;

  assign idle      = now_i - last_i;
  assign timed_out = (timeout_i != '0) && (last_i != '0) &&
                     (idle > {{(frer_vr_pkg::TimeW - frer_vr_pkg::TmoW){1'b0}}, timeout_i});
  assign restart   = !valid_i || timed_out;
  assign ahead     = seq_i - base_i;
  assign offset    = base_i - seq_i;
  // newer when the signed distance is positive
  assign newer     = (ahead != '0) && !ahead[frer_vr_pkg::SeqW-1];
  assign bit_m     = WINDOW'(1) << offset;

  always_comb begin
    base_d_o  = base_i;
    seen_d_o  = seen_i;
    verdict_o = '{accept: 1'b1, cause: frer_vr_pkg::CauseRestart};
    if (restart) begin
      base_d_o = seq_i;
      seen_d_o = WINDOW'(1);
    end else if (newer) begin
      base_d_o  = seq_i;
      seen_d_o  = ((ahead >= WinW) ? '0 : (seen_i << ahead)) | WINDOW'(1);
      verdict_o = '{accept: 1'b1, cause: frer_vr_pkg::CauseAdvance};
    end else if (offset >= WinW) begin
      verdict_o = '{accept: 1'b0, cause: frer_vr_pkg::CauseOutside};
    end else if ((seen_i & bit_m) != '0) begin
      verdict_o = '{accept: 1'b0, cause: frer_vr_pkg::CauseDup};
    end else begin
      seen_d_o  = seen_i | bit_m;
      verdict_o = '{accept: 1'b1, cause: frer_vr_pkg::CauseGap};
    end
  end

endmodule

`default_nettype wire

// ===== bench/frer_vr_verdict_check.sv =====
`timescale 1ns / 100ps

module frer_vr_verdict_check #(
  parameter int unsigned WINDOW = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  input  wire logic                                 in_ready_i,
  input  wire logic [frer_vr_pkg::SeqW-1:0]         sequence_req_i,
  input  wire logic [frer_vr_pkg::TimeW-1:0]        now_time_i,
  input  wire logic                                 out_valid_i,
  input  wire logic                                 out_ready_i,
  input  wire logic                                 accept_i,
  input  wire logic [frer_vr_pkg::CauseW-1:0]       cause_i,
  input  wire logic                                 cfg_valid_i,
  input  wire logic                                 cfg_ready_i,
  input  wire logic [frer_vr_pkg::TmoW-1:0]         recovery_timeout_i,
  output int unsigned                               pending_o,
  output int unsigned                               errors_o
);

  localparam logic [63:0] WinMask = (WINDOW >= 64) ? '1 : ((64'd1 << WINDOW) - 64'd1);

  // Mirror of the recovery state
  logic                            win_valid;
  logic [frer_vr_pkg::SeqW-1:0]    win_base;
  logic [63:0]                     seen_bits;
  logic [frer_vr_pkg::TimeW-1:0]   last_time;
  logic [frer_vr_pkg::TmoW-1:0]    timeout;

  frer_vr_pkg::verdict_t verdicts_q[$];

  // Decide one frame and update the mirrored window
  function automatic frer_vr_pkg::verdict_t decide_frame(
      input logic [frer_vr_pkg::SeqW-1:0] seq,
      input logic [frer_vr_pkg::TimeW-1:0] now);
    frer_vr_pkg::verdict_t         v;
    logic [frer_vr_pkg::SeqW-1:0]  ahead;
    logic [frer_vr_pkg::SeqW-1:0]  offset;
    ahead  = seq - win_base;
    offset = win_base - seq;
    if (!win_valid ||
        (timeout != '0 && last_time != '0 && (now - last_time) > {32'd0, timeout})) begin
      win_valid = 1'b1;
      win_base  = seq;
      seen_bits = 64'd1;
      v.accept  = 1'b1;
      v.cause   = frer_vr_pkg::CauseRestart;
    end else if (ahead != '0 && !ahead[frer_vr_pkg::SeqW-1]) begin
      seen_bits    = (ahead >= WINDOW) ? 64'd0 : ((seen_bits << ahead) & WinMask);
      seen_bits[0] = 1'b1;
      win_base     = seq;
      v.accept     = 1'b1;
      v.cause      = frer_vr_pkg::CauseAdvance;
    end else if (offset >= WINDOW) begin
      v.accept = 1'b0;
      v.cause  = frer_vr_pkg::CauseOutside;
    end else if (seen_bits[offset]) begin
      v.accept = 1'b0;
      v.cause  = frer_vr_pkg::CauseDup;
    end else begin
      seen_bits[offset] = 1'b1;
      v.accept = 1'b1;
      v.cause  = frer_vr_pkg::CauseGap;
    end
    last_time = now;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frer_vr_pkg::verdict_t want;
    if (!rst_ni) begin
      win_valid = 1'b0;
      win_base  = '0;
      seen_bits = '0;
      last_time = '0;
      timeout   = '0;
      verdicts_q.delete();
      errors_o  = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        timeout = recovery_timeout_i;
      end
      if (in_valid_i && in_ready_i) begin
        verdicts_q.push_back(decide_frame(sequence_req_i, now_time_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (verdicts_q.size() == 0) begin
          $error("result beat with no frame outstanding: accept %0d cause %0d",
                 accept_i, cause_i);
          errors_o++;
        end else begin
          want = verdicts_q.pop_front();
          if (accept_i !== want.accept) begin
            $error("accept: expected %0d, got %0d", want.accept, accept_i);
            errors_o++;
          end
          if (cause_i !== want.cause) begin
            $error("cause: expected %0d, got %0d", want.cause, cause_i);
            errors_o++;
          end
        end
      end
      pending_o <= verdicts_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned PhaseFrames = 180;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [frer_vr_pkg::SeqW-1:0]      sequence_req = '0;
  logic [frer_vr_pkg::TimeW-1:0]     now_time = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              accept;
  logic [frer_vr_pkg::CauseW-1:0]    cause;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [frer_vr_pkg::TmoW-1:0]      recovery_timeout = '0;

  int unsigned pending;
  int unsigned errors;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  // Stream generator state
  logic [frer_vr_pkg::SeqW-1:0]   gen_seq = '0;
  logic [frer_vr_pkg::TimeW-1:0]  gen_time = '0;
  logic [frer_vr_pkg::TmoW-1:0]   cur_timeout = '0;

  always #4 clk_i = ~clk_i;

  frer_vector_recovery DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .sequence_req_i     (sequence_req),
    .now_time_i         (now_time),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .accept_o           (accept),
    .cause_o            (cause),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .recovery_timeout_i (recovery_timeout)
  );

  frer_vr_verdict_check u_verdict_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .sequence_req_i     (sequence_req),
    .now_time_i         (now_time),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .accept_i           (accept),
    .cause_i            (cause),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .recovery_timeout_i (recovery_timeout),
    .pending_o          (pending),
    .errors_o           (errors)
  );

  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_frame(input logic [frer_vr_pkg::SeqW-1:0] seq,
                            input logic [frer_vr_pkg::TimeW-1:0] now);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    sequence_req <= seq;
    now_time     <= now;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Hold off until every verdict is back and the pipeline is empty
  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [frer_vr_pkg::TmoW-1:0] value);
    drain_frames();
    cfg_valid        <= 1'b1;
    recovery_timeout <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    cur_timeout = value;
  endtask

  // Two redundant paths: mostly in-order new frames and their copies, with
  // stragglers, jumps and the odd stray sequence number
  task automatic send_stream_frame();
    int unsigned                   pick;
    int unsigned                   tick;
    logic [frer_vr_pkg::SeqW-1:0]  seq;
    pick = $urandom_range(0, 99);
    tick = $urandom_range(0, 99);
    if (pick < 45) begin
      gen_seq = 16'(gen_seq + (($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1));
      seq = gen_seq;
    end else if (pick < 70) begin
      seq = 16'(gen_seq - $urandom_range(0, 8));
    end else if (pick < 80) begin
      seq = 16'(gen_seq - $urandom_range(9, 70));
    end else if (pick < 85) begin
      gen_seq = 16'(gen_seq + ($urandom_range(0, 1) ? $urandom_range(6, 300)
                                                    : $urandom_range(16'h4000, 16'h7FFF)));
      seq = gen_seq;
    end else if (pick < 88 && cur_timeout != '0) begin
      seq = 16'(gen_seq + $urandom_range(16'h7FF8, 16'h8008));
    end else if (pick < 93 && cur_timeout != '0) begin
      seq = 16'($urandom);
    end else begin
      seq = 16'(gen_seq - $urandom_range(62, 65));
    end

    if (tick < 2) begin
      gen_time = {$urandom, $urandom};
    end else if (tick < 3) begin
      gen_time = '0;
    end else if (tick < 7) begin
      gen_time = gen_time + cur_timeout + $urandom_range(1, 1000) + $urandom;
    end else if (tick < 10) begin
      gen_time = gen_time + cur_timeout + $urandom_range(0, 1);
    end else if (cur_timeout == '0) begin
      gen_time = gen_time + $urandom_range(1, 5000);
    end else begin
      gen_time = gen_time + $urandom_range(0, cur_timeout / 2 + 1);
    end
    send_frame(seq, gen_time);
  endtask

  task automatic run_phase(input logic [frer_vr_pkg::TmoW-1:0] value, input bit quiet_stretch);
    write_timeout(value);
    for (int i = 0; i < PhaseFrames; i++) begin
      calm = quiet_stretch && (i >= 40) && (i < 140);
      send_stream_frame();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Window bookkeeping with the timeout off
    send_frame(16'd100, 64'd10);
    send_frame(16'd100, 64'd11);
    send_frame(16'd101, 64'd12);
    send_frame(16'd99, 64'd13);
    send_frame(16'd99, 64'd14);
    send_frame(16'd164, 64'd15);
    send_frame(16'd101, 64'd16);
    send_frame(16'd100, 64'd17);
    send_frame(16'd228, 64'd18);
    send_frame(16'd32995, 64'd19);
    send_frame(16'd227, 64'd20);
    send_frame(16'hFFFF, 64'd0);
    send_frame(16'h0000, 64'd21);
    send_frame(16'hFFFE, 64'hFFFF_FFFF_FFFF_FFFF);

    // Shortest timeout, time wrapping and a last-seen time of zero
    write_timeout(32'd1);
    send_frame(16'd5, 64'd100);
    send_frame(16'd6, 64'd101);
    send_frame(16'd7, 64'd103);
    send_frame(16'd8, 64'd0);
    send_frame(16'd8, 64'd1000);

    // Longest timeout: exactly at the limit and one past it
    write_timeout(32'hFFFF_FFFF);
    send_frame(16'd9, 64'd2000);
    send_frame(16'd10, 64'd2000 + 64'h0000_0000_FFFF_FFFF);
    gen_time = 64'd2000 + 64'h0000_0000_FFFF_FFFF + 64'h0000_0001_0000_0000;
    send_frame(16'd11, gen_time);
    send_frame(16'd11, gen_time);
    gen_seq = 16'd11;

    run_phase(32'd0, 1'b0);
    run_phase($urandom_range(200, 20000), 1'b1);
    run_phase(32'hFFFF_FFFF, 1'b0);
    run_phase($urandom, 1'b0);
    run_phase(32'd1, 1'b0);

    drain_frames();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== frer_vector_recovery.f =====
hw/rtl/frer_vr_pkg.sv
hw/rtl/frer_vr_decide.sv
hw/rtl/frer_vector_recovery.sv
bench/frer_vr_verdict_check.sv
bench/tb.sv
